// ===== design/button_event_qualifier_defines.svh =====
// Assertion macros for the button event qualifier.
// Included by the modules that carry concurrent assertions; uses their clk and arst_n.
`ifndef BUTTON_EVENT_QUALIFIER_DEFINES_SVH
`define BUTTON_EVENT_QUALIFIER_DEFINES_SVH

// same-cycle implication
`define BEVQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BEVQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bevq_pkg.sv =====
// Shared types and constants of the button event qualifier.
// No dependencies; used by the interfaces, controller, datapath and top level.
package bevq_pkg;

	localparam int NOW_W      = 32;
	localparam int COLOR_W    = 24;
	localparam int MASK_W     = 5;
	localparam int IDX_W      = 5;
	localparam int DLY_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int FLAGS_W    = 3;

	typedef enum logic [1:0] {
		OP_POLL  = 2'd0,
		OP_SET   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HILITE   = 2'd3;

	localparam logic [DLY_W-1:0]   DEBOUNCE_RST = 16'd30;
	localparam logic [DLY_W-1:0]   LONG_RST     = 16'd800;
	localparam logic [DLY_W-1:0]   REPEAT_RST   = 16'd300;
	localparam logic [COLOR_W-1:0] HILITE_RST   = 24'hFFFFFF;

	// flag bit positions
	localparam int FLAG_PRESSED = 0;
	localparam int FLAG_WHITE   = 1;
	localparam int FLAG_HANDLED = 2;

	// event mask bit positions
	localparam int EV_PRESS   = 0;
	localparam int EV_RELEASE = 1;
	localparam int EV_CLICK   = 2;
	localparam int EV_LONG    = 3;
	localparam int EV_REPEAT  = 4;

	// repeat interval = 100 - floor(9 * ramp / 100), ramp clamped to 1000 ms
	// floor(9*r/100) == (r * 9 * 10486) >> 20 for r <= 1000
	localparam int               RAMP_W      = 10;
	localparam logic [RAMP_W-1:0] RAMP_MAX   = 10'd1000;
	localparam int               INTV_W      = 7;
	localparam logic [INTV_W-1:0] REPEAT_SLOW = 7'd100;
	localparam int               RAMP_MUL_W  = 17;
	localparam logic [RAMP_MUL_W-1:0] RAMP_MUL = 17'd94374;
	localparam int               RAMP_SHIFT  = 20;

	typedef struct packed {
		logic [FLAGS_W-1:0] flags;
		logic [MASK_W-1:0]  mask;
		logic [COLOR_W-1:0] color;
		logic [NOW_W-1:0]   press;
		logic [NOW_W-1:0]   deb;
		logic [NOW_W-1:0]   rep;
		logic [COLOR_W-1:0] shown;
	} entry_t;

	typedef struct packed {
		logic load;
		logic calc_diff;
		logic calc_mult;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic has_result;
		logic out_busy;
	} stat_t;

endpackage

// ===== design/bevq_ifs.sv =====
// Valid/ready channel interfaces for poll requests and button events.
// Depends on bevq_pkg for field widths.
interface bevq_req_if;
	import bevq_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [IDX_W-1:0]   button_index;
	logic               pressed;
	logic [NOW_W-1:0]   now_ms;
	logic [MASK_W-1:0]  type_mask;
	logic [COLOR_W-1:0] color;

	modport source (output valid, operation, button_index, pressed, now_ms, type_mask, color,
		input ready);
	modport sink (input valid, operation, button_index, pressed, now_ms, type_mask, color,
		output ready);
endinterface

interface bevq_evt_if;
	import bevq_pkg::*;
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   event_button;
	logic               press_event;
	logic               release_event;
	logic               click_event;
	logic               long_click_event;
	logic [COLOR_W-1:0] led_color;
	logic               led_write;
	logic               led_force;

	modport source (output valid, event_button, press_event, release_event, click_event,
		long_click_event, led_color, led_write, led_force, input ready);
	modport sink (input valid, event_button, press_event, release_event, click_event,
		long_click_event, led_color, led_write, led_force, output ready);
endinterface

// ===== design/bevq_ctrl.sv =====
// Sequencing controller: accept, difference, ramp, commit.
// Depends on bevq_pkg and button_event_qualifier_defines.svh.
`include "button_event_qualifier_defines.svh"

module bevq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bevq_pkg::stat_t stat,
	output bevq_pkg::cmd_t  cmd
);
	import bevq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIFF,
		S_MULT,
		S_WRITE
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   stall;

	// hold the commit while a finished result still waits downstream
	assign stall = stat.has_result && stat.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DIFF;
						ready_q <= 1'b0;
					end
				end
				S_DIFF: state_q <= S_MULT;
				S_MULT: state_q <= S_WRITE;
				S_WRITE: begin
					if (!stall) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = ready_q;

	always_comb begin
		cmd.load      = ready_q && in_valid;
		cmd.calc_diff = (state_q == S_DIFF);
		cmd.calc_mult = (state_q == S_MULT);
		cmd.commit    = (state_q == S_WRITE) && !stall;
	end

	`BEVQ_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0({cmd.load, cmd.calc_diff, cmd.calc_mult, cmd.commit}), "more than one command active")
	`BEVQ_ASSERT_NEXT(a_load_then_diff, cmd.load, cmd.calc_diff && !in_ready, "load not followed by difference step")
	`BEVQ_ASSERT_NEXT(a_diff_then_mult, cmd.calc_diff, cmd.calc_mult, "difference not followed by ramp step")
	`BEVQ_ASSERT_NOW(a_no_overwrite, cmd.commit && stat.has_result, !stat.out_busy, "result committed over a pending transfer")

endmodule

// ===== design/bevq_dp.sv =====
// Datapath: button table memory, config registers, event logic, output register.
// Depends on bevq_pkg; driven by bevq_ctrl commands.
module bevq_dp #(
	parameter int BUTTON_COUNT = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bevq_pkg::cmd_t                      cmd,
	output bevq_pkg::stat_t                     stat,
	input  logic                                cfg_we,
	input  logic [bevq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bevq_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [1:0]                          req_operation,
	input  logic [bevq_pkg::IDX_W-1:0]          req_button_index,
	input  logic                                req_pressed,
	input  logic [bevq_pkg::NOW_W-1:0]          req_now_ms,
	input  logic [bevq_pkg::MASK_W-1:0]         req_type_mask,
	input  logic [bevq_pkg::COLOR_W-1:0]        req_color,
	output logic                                evt_valid,
	input  logic                                evt_ready,
	output logic [bevq_pkg::IDX_W-1:0]          evt_event_button,
	output logic                                evt_press_event,
	output logic                                evt_release_event,
	output logic                                evt_click_event,
	output logic                                evt_long_click_event,
	output logic [bevq_pkg::COLOR_W-1:0]        evt_led_color,
	output logic                                evt_led_write,
	output logic                                evt_led_force
);
	import bevq_pkg::*;

	localparam int AW  = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
	localparam int CW  = 7;

	// config
	logic [DLY_W-1:0]   debounce_q, long_q, repeat_q;
	logic [COLOR_W-1:0] hilite_q;

	// table
	entry_t                 mem [BUTTON_COUNT];
	logic [BUTTON_COUNT-1:0] valid_q;

	// held item
	logic [1:0]         op_q;
	logic [IDX_W-1:0]   idx_q;
	logic [AW-1:0]      addr_q;
	logic               range_q;
	logic               pressed_q;
	logic [NOW_W-1:0]   now_q;
	logic [MASK_W-1:0]  tmask_q;
	logic [COLOR_W-1:0] tcolor_q;

	entry_t             ent_s1;
	logic               ent_vld_s1;
	entry_t             cur;

	logic [NOW_W-1:0]   dpress_s2, drep_s2, ddeb_s2;
	logic               rep_gt_s3, long_gt_s3, window_s3;
	logic [RAMP_W-1:0]  clamp_s3;
	logic [NOW_W-1:0]   ext;

	logic [RAMP_W+RAMP_MUL_W-1:0] ramp_prod;
	logic [INTV_W-1:0]  interval;
	logic               rep_due;

	entry_t             nxt;
	logic               ev_press, ev_rel, ev_click, ev_long, force_ref;
	logic [COLOR_W-1:0] led_rgb;
	logic               is_poll, has_result, do_write;
	logic               was_p, handled;

	assign cur = ent_vld_s1 ? ent_s1 : '0;

	// ramp arithmetic feeding the commit step
	assign ext = dpress_s2 - NOW_W'(repeat_q);
	assign ramp_prod = (RAMP_W+RAMP_MUL_W)'(clamp_s3) * (RAMP_W+RAMP_MUL_W)'(RAMP_MUL);
	assign interval  = REPEAT_SLOW - ramp_prod[RAMP_SHIFT +: INTV_W];
	assign rep_due   = drep_s2 > NOW_W'(interval);

	assign is_poll    = (op_q == OP_POLL);
	assign has_result = is_poll && range_q && (cur.mask != '0) && !window_s3;
	assign do_write   = range_q && (has_result || op_q == OP_SET || op_q == OP_CLEAR);
	assign was_p      = cur.flags[FLAG_PRESSED];
	assign handled    = cur.flags[FLAG_HANDLED];

	always_comb begin
		nxt       = cur;
		ev_press  = 1'b0;
		ev_rel    = 1'b0;
		ev_click  = 1'b0;
		ev_long   = 1'b0;
		force_ref = 1'b0;
		case (op_q)
			OP_SET: begin
				nxt.mask  = tmask_q;
				nxt.color = tcolor_q;
			end
			OP_CLEAR: begin
				nxt.mask  = '0;
				nxt.color = '0;
				nxt.press = '0;
				nxt.deb   = '0;
				nxt.rep   = '0;
			end
			OP_POLL: begin
				nxt.deb = '0;
				if (pressed_q != was_p) begin
					nxt.deb = now_q;
					if (pressed_q) begin
						nxt.press = now_q;
						nxt.flags = '0;
						nxt.flags[FLAG_PRESSED] = 1'b1;
						if (cur.mask[EV_PRESS]) ev_press = 1'b1;
						else nxt.flags[FLAG_WHITE] = 1'b1;
					end else begin
						if (!handled) begin
							force_ref = 1'b1;
							ev_rel    = cur.mask[EV_RELEASE];
							ev_click  = cur.mask[EV_CLICK];
						end
						nxt.flags = '0;
						nxt.press = '0;
						nxt.rep   = '0;
					end
				end else if (pressed_q && was_p && !handled) begin
					if (cur.mask[EV_REPEAT] && rep_gt_s3) begin
						if (rep_due) begin
							ev_press = 1'b1;
							nxt.rep  = now_q;
						end
					end else if (cur.mask[EV_LONG] && long_gt_s3) begin
						nxt.flags[FLAG_HANDLED] = 1'b1;
						nxt.flags[FLAG_WHITE]   = 1'b0;
						force_ref = 1'b1;
						ev_long   = 1'b1;
					end
				end
			end
			default: ;
		endcase
		led_rgb = nxt.flags[FLAG_WHITE] ? hilite_q : nxt.color;
		if (is_poll) nxt.shown = led_rgb;
	end

	// memory and payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ent_s1    <= mem[AW'(req_button_index)];
			op_q      <= req_operation;
			idx_q     <= req_button_index;
			addr_q    <= AW'(req_button_index);
			range_q   <= (CW'(req_button_index) < CW'(BUTTON_COUNT));
			pressed_q <= req_pressed;
			now_q     <= req_now_ms;
			tmask_q   <= req_type_mask;
			tcolor_q  <= req_color;
		end
		if (cmd.calc_diff) begin
			dpress_s2 <= now_q - cur.press;
			drep_s2   <= now_q - cur.rep;
			ddeb_s2   <= now_q - cur.deb;
		end
		if (cmd.calc_mult) begin
			rep_gt_s3  <= dpress_s2 > NOW_W'(repeat_q);
			long_gt_s3 <= dpress_s2 > NOW_W'(long_q);
			window_s3  <= (cur.deb != '0) && (ddeb_s2 < NOW_W'(debounce_q));
			clamp_s3   <= (ext > NOW_W'(RAMP_MAX)) ? RAMP_MAX : ext[RAMP_W-1:0];
		end
		if (cmd.commit && do_write) begin
			mem[addr_q] <= nxt;
		end
		if (cmd.commit && has_result) begin
			evt_event_button     <= idx_q;
			evt_press_event      <= ev_press;
			evt_release_event    <= ev_rel;
			evt_click_event      <= ev_click;
			evt_long_click_event <= ev_long;
			evt_led_color        <= led_rgb;
			evt_led_write        <= (cur.shown != led_rgb);
			evt_led_force        <= force_ref;
		end
	end

	// control state: config, valid bits, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			long_q     <= LONG_RST;
			repeat_q   <= REPEAT_RST;
			hilite_q   <= HILITE_RST;
			valid_q    <= '0;
			ent_vld_s1 <= 1'b0;
			evt_valid  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEBOUNCE: debounce_q <= cfg_data[DLY_W-1:0];
					CFG_LONG:     long_q     <= cfg_data[DLY_W-1:0];
					CFG_REPEAT:   repeat_q   <= cfg_data[DLY_W-1:0];
					CFG_HILITE:   hilite_q   <= cfg_data[COLOR_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) ent_vld_s1 <= valid_q[AW'(req_button_index)];
			if (cmd.commit && do_write) valid_q[addr_q] <= 1'b1;
			if (cmd.commit && has_result) evt_valid <= 1'b1;
			else if (evt_ready) evt_valid <= 1'b0;
		end
	end

	assign stat.has_result = has_result;
	assign stat.out_busy   = evt_valid && !evt_ready;

endmodule

// ===== design/button_event_qualifier.sv =====
// Button event qualifier: debounce, press/release/click, long click, auto-repeat, LED color.
// The req transfer reads the table; difference, ramp and write steps follow, and the result
//   is registered on evt at the commit. One item at a time: the next is taken only after the
//   sequence over the single-port button table ends, including any wait of the commit on evt.
// Reset (arst_n low, asynchronous): config to defaults, all table entries read as zero
//   through per-entry valid bits, no clearing pass; accepts items from the first cycle.
module button_event_qualifier #(
	parameter int BUTTON_COUNT = 25
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bevq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bevq_pkg::CFG_DATA_W-1:0] cfg_data,
	bevq_req_if.sink                        req,
	bevq_evt_if.source                      evt
);
	import bevq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// controller: one item at a time, ready only while idle
	bevq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: table read on the transfer edge, read-modify-write on commit;
	// the output register lets a new item start while a result waits
	bevq_dp #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.req_operation        (req.operation),
		.req_button_index     (req.button_index),
		.req_pressed          (req.pressed),
		.req_now_ms           (req.now_ms),
		.req_type_mask        (req.type_mask),
		.req_color            (req.color),
		.evt_valid            (evt.valid),
		.evt_ready            (evt.ready),
		.evt_event_button     (evt.event_button),
		.evt_press_event      (evt.press_event),
		.evt_release_event    (evt.release_event),
		.evt_click_event      (evt.click_event),
		.evt_long_click_event (evt.long_click_event),
		.evt_led_color        (evt.led_color),
		.evt_led_write        (evt.led_write),
		.evt_led_force        (evt.led_force)
	);

endmodule
